[design/lpfd_pkg.sv]
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned LEN_W      = 32;
	localparam int unsigned KIND_W     = 2;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;

	localparam logic [BYTE_W-1:0] DELIM_BYTE    = 8'h0F;
	localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 32'd1048576;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_PAYLOAD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EMPTY     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BAD_DELIM = 2'd2;
	localparam logic [KIND_W-1:0] KIND_TOO_LONG  = 2'd3;

	// register map, index taken from paddr[2]
	localparam logic REG_MAX_LEN = 1'b0;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [KIND_W-1:0] kind_t;

	typedef struct packed {
		kind_t kind;
		byte_t payload_byte;
		logic  last_byte;
	} result_t;

endpackage

[design/lpfd_ifs.sv]
// ----------------------------------------------------------------------------
// lpfd_ifs
// Valid/ready stream channels: received bytes in, deframed results out.
// ----------------------------------------------------------------------------
interface lpfd_in_if;
	logic                      valid;
	logic                      ready;
	logic [lpfd_pkg::BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface lpfd_out_if;
	logic                        valid;
	logic                        ready;
	logic [lpfd_pkg::KIND_W-1:0] kind;
	logic [lpfd_pkg::BYTE_W-1:0] payload_byte;
	logic                        last_byte;

	modport source (output valid, output kind, output payload_byte, output last_byte,
		input ready);
	modport sink   (input valid, input kind, input payload_byte, input last_byte,
		output ready);
endinterface

[design/lpfd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lpfd_cfg_regs
// APB register slave holding the maximum accepted message length.
// ----------------------------------------------------------------------------
module lpfd_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lpfd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lpfd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lpfd_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output logic [lpfd_pkg::LEN_W-1:0]      max_len
);
	import lpfd_pkg::*;

	len_t max_len_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (wr_en && paddr[2] == REG_MAX_LEN) begin
			max_len_q <= pwdata;
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_MAX_LEN: prdata = max_len_q;
			default:     prdata = '0;
		endcase
	end

	assign max_len = max_len_q;

endmodule

[design/lpfd_core.sv]
// ----------------------------------------------------------------------------
// lpfd_core
// Input register, frame parser state and result register.
// ----------------------------------------------------------------------------
module lpfd_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lpfd_pkg::LEN_W-1:0] max_len,
	lpfd_in_if.sink                    in_ch,
	lpfd_out_if.source                 out_ch
);
	import lpfd_pkg::*;

	localparam logic [2:0] PH_WAIT    = 3'd0;
	localparam logic [2:0] PH_LEN1    = 3'd1;
	localparam logic [2:0] PH_LEN2    = 3'd2;
	localparam logic [2:0] PH_LEN3    = 3'd3;
	localparam logic [2:0] PH_LEN4    = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;

	// input register
	logic    valid_s1;
	byte_t   byte_s1;
	// parser state
	logic [2:0] phase_q, phase_d;
	len_t    len_q, len_d;
	len_t    rem_q, rem_d;
	// result register
	logic    out_valid_q;
	result_t res_q, res_d;

	logic has_res;
	logic out_free;
	logic s1_fire;
	logic in_fire;
	len_t len_shift;

	assign out_free  = !out_valid_q || out_ch.ready;
	assign s1_fire   = valid_s1 && (!has_res || out_free);
	assign in_ch.ready = !valid_s1 || s1_fire;
	assign in_fire   = in_ch.valid && in_ch.ready;
	assign len_shift = {len_q[LEN_W-BYTE_W-1:0], byte_s1};

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		rem_d   = rem_q;
		has_res = 1'b0;
		res_d   = '{kind: KIND_PAYLOAD, payload_byte: '0, last_byte: 1'b1};
		unique case (phase_q) inside
			[PH_LEN1:PH_LEN3]: begin
				len_d   = len_shift;
				phase_d = phase_q + 3'd1;
			end
			PH_LEN4: begin
				len_d = len_shift;
				if (len_shift > max_len) begin
					has_res    = 1'b1;
					res_d.kind = KIND_TOO_LONG;
					phase_d    = PH_WAIT;
				end else if (len_shift == '0) begin
					has_res    = 1'b1;
					res_d.kind = KIND_EMPTY;
					phase_d    = PH_WAIT;
				end else begin
					rem_d   = len_shift;
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				has_res            = 1'b1;
				res_d.payload_byte = byte_s1;
				res_d.last_byte    = (rem_q <= len_t'(1));
				if (rem_q != '0) begin
					rem_d = rem_q - len_t'(1);
				end
				if (rem_q <= len_t'(1)) begin
					phase_d = PH_WAIT;
				end
			end
			default: begin
				if (byte_s1 == DELIM_BYTE) begin
					len_d   = '0;
					phase_d = PH_LEN1;
				end else begin
					has_res    = 1'b1;
					res_d.kind = KIND_BAD_DELIM;
					phase_d    = PH_WAIT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_WAIT;
			len_q       <= '0;
			rem_q       <= '0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (s1_fire) begin
				phase_q <= phase_d;
				len_q   <= len_d;
				rem_q   <= rem_d;
			end
			if (s1_fire && has_res) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= in_ch.in_byte;
		end
		if (s1_fire && has_res) begin
			res_q <= res_d;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.kind         = res_q.kind;
	assign out_ch.payload_byte = res_q.payload_byte;
	assign out_ch.last_byte    = res_q.last_byte;

endmodule

[design/length_prefixed_frame_deframer_unit.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_unit
// Strips 0x0F delimiter and 4-byte big-endian length from a byte stream,
// emitting payload bytes with a last mark, or an empty/error word.
//
//   channel | dir | handshake      | word
//   in_ch   | in  | valid/ready    | in_byte
//   out_ch  | out | valid/ready    | kind, payload_byte, last_byte
//   apb     | in  | psel/penable   | reg 0 max_message_length at 0x0
//
// One byte per cycle while out_ch keeps taking results; a byte's result
// reaches out_ch via the input register, then the result register.
// Reset clears the parser to waiting for a delimiter and max length to 1 MiB.
// A byte that produces no result still moves while the result register waits
// to be taken; a byte with a result waits in the input register and holds
// in_ch.ready low until the result register is free.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	lpfd_in_if.sink                         in_ch,
	lpfd_out_if.source                      out_ch,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lpfd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lpfd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lpfd_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import lpfd_pkg::*;

	len_t max_len;

	lpfd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.max_len (max_len)
	);

	lpfd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.max_len (max_len),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

endmodule
